// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL.
// Simulation builds get the checks; synthesis builds define SYNTH and get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: assertion failed");

// Check that a condition holds in the cycle after a trigger
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond)

`endif

`endif

// ===== src/pbrq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pbrq_pkg;

    // Field widths of the request and response channels
    localparam int MODE_W    = 2;
    localparam int TASK_ID_W = 6;
    localparam int PRIO_W    = 5;

    // Default sizing
    localparam int DEF_NUM_LEVELS = 32;
    localparam int DEF_MAX_TASKS  = 64;

    // Width of the level bitmap seen by the search
    localparam int LEVEL_VEC_W = 32;
    localparam int LEVEL_IDX_W = $clog2(LEVEL_VEC_W);

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;

    // Write strobes for the list stores
    typedef struct packed {
        logic head;
        logic tail;
        logic next;
        logic prev;
        logic level;
    } pbrq_wr_en_t;

    // Index of the lowest set bit, zero when none is set
    function automatic logic [LEVEL_IDX_W-1:0] tzc32(input logic [LEVEL_VEC_W-1:0] v);
        logic [LEVEL_IDX_W-1:0] r;
        r = '0;
        for (int i = LEVEL_VEC_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = LEVEL_IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/pbrq_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pbrq_req_if;
    logic                           valid;
    logic                           ready;
    logic [pbrq_pkg::MODE_W-1:0]    mode;
    logic [pbrq_pkg::TASK_ID_W-1:0] task_id;
    logic [pbrq_pkg::PRIO_W-1:0]    task_prio;

    modport source (output valid, mode, task_id, task_prio, input ready);
    modport sink   (input valid, mode, task_id, task_prio, output ready);
endinterface

`default_nettype wire

// ===== src/pbrq_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pbrq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [pbrq_pkg::TASK_ID_W-1:0] head_task;
    logic                           status;

    modport source (output valid, found, head_task, status, input ready);
    modport sink   (input valid, found, head_task, status, output ready);
endinterface

`default_nettype wire

// ===== src/pbrq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, new data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/pbrq_link_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pbrq_link_ctrl #(
    parameter int NUM_LEVELS = pbrq_pkg::DEF_NUM_LEVELS,
    parameter int MAX_TASKS  = pbrq_pkg::DEF_MAX_TASKS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               fire,
    input  wire logic [pbrq_pkg::MODE_W-1:0]        mode,
    input  wire logic [pbrq_pkg::TASK_ID_W-1:0]     task_id,
    input  wire logic [pbrq_pkg::PRIO_W-1:0]        task_prio,
    input  wire logic [$clog2(MAX_TASKS)-1:0]       tail_rd,
    input  wire logic [$clog2(MAX_TASKS)-1:0]       next_rd,
    input  wire logic [$clog2(MAX_TASKS)-1:0]       prev_rd,
    input  wire logic [$clog2(NUM_LEVELS)-1:0]      level_rd,
    output pbrq_pkg::pbrq_wr_en_t                   wr,
    output logic      [$clog2(NUM_LEVELS)-1:0]      head_waddr,
    output logic      [$clog2(MAX_TASKS)-1:0]       head_wdata,
    output logic      [$clog2(NUM_LEVELS)-1:0]      tail_waddr,
    output logic      [$clog2(MAX_TASKS)-1:0]       tail_wdata,
    output logic      [$clog2(MAX_TASKS)-1:0]       next_waddr,
    output logic      [$clog2(MAX_TASKS)-1:0]       next_wdata,
    output logic      [$clog2(MAX_TASKS)-1:0]       prev_waddr,
    output logic      [$clog2(MAX_TASKS)-1:0]       prev_wdata,
    output logic      [$clog2(MAX_TASKS)-1:0]       level_waddr,
    output logic      [$clog2(NUM_LEVELS)-1:0]      level_wdata,
    output logic      [$clog2(NUM_LEVELS)-1:0]      head_raddr,
    output logic                                    found,
    output logic                                    status
);

    import pbrq_pkg::*;

    localparam int TID_W = $clog2(MAX_TASKS);
    localparam int LVL_W = $clog2(NUM_LEVELS);

    logic [NUM_LEVELS-1:0] mask_reg, mask_next;
    logic [MAX_TASKS-1:0]  queued_reg, queued_next;
    logic [MAX_TASKS-1:0]  has_prev_reg, has_prev_next;
    logic [MAX_TASKS-1:0]  has_next_reg, has_next_next;

    logic             id_ok, prio_ok, is_queued, add_ok, rem_ok;
    logic             level_empty, is_head, is_tail;
    logic [TID_W-1:0] id;
    logic [LVL_W-1:0] lvl_add;

    // Decode the request and check it against the queue state
    always_comb
    begin
        id_ok       = 32'(task_id) < 32'(MAX_TASKS);
        prio_ok     = 32'(task_prio) < 32'(NUM_LEVELS);
        id          = TID_W'(task_id);
        lvl_add     = LVL_W'(task_prio);
        is_queued   = id_ok ? queued_reg[id] : 1'b0;
        add_ok      = (mode == MODE_ADD) && id_ok && prio_ok && !is_queued;
        rem_ok      = (mode == MODE_REMOVE) && is_queued;
        level_empty = prio_ok ? !mask_reg[lvl_add] : 1'b0;
        is_head     = id_ok ? !has_prev_reg[id] : 1'b0;
        is_tail     = id_ok ? !has_next_reg[id] : 1'b0;
        status      = ((mode == MODE_ADD) && !add_ok) || ((mode == MODE_REMOVE) && !rem_ok);
    end

    // Work out the list edits for this request
    always_comb
    begin
        mask_next     = mask_reg;
        queued_next   = queued_reg;
        has_prev_next = has_prev_reg;
        has_next_next = has_next_reg;
        wr            = '0;
        head_waddr    = lvl_add;
        head_wdata    = id;
        tail_waddr    = lvl_add;
        tail_wdata    = id;
        next_waddr    = tail_rd;
        next_wdata    = id;
        prev_waddr    = id;
        prev_wdata    = tail_rd;
        level_waddr   = id;
        level_wdata   = lvl_add;

        if (fire && add_ok)
        begin
            // Append at the tail of the level
            wr.level          = 1'b1;
            wr.tail           = 1'b1;
            queued_next[id]   = 1'b1;
            has_next_next[id] = 1'b0;
            if (level_empty)
            begin
                wr.head            = 1'b1;
                mask_next[lvl_add] = 1'b1;
                has_prev_next[id]  = 1'b0;
            end
            else
            begin
                wr.next                = 1'b1;
                wr.prev                = 1'b1;
                has_next_next[tail_rd] = 1'b1;
                has_prev_next[id]      = 1'b1;
            end
        end
        else if (fire && rem_ok)
        begin
            // Unlink from the recorded level
            queued_next[id] = 1'b0;
            if (is_head && is_tail)
            begin
                mask_next[level_rd] = 1'b0;
            end
            else if (is_head)
            begin
                wr.head                = 1'b1;
                head_waddr             = level_rd;
                head_wdata             = next_rd;
                has_prev_next[next_rd] = 1'b0;
            end
            else if (is_tail)
            begin
                wr.tail                = 1'b1;
                tail_waddr             = level_rd;
                tail_wdata             = prev_rd;
                has_next_next[prev_rd] = 1'b0;
            end
            else
            begin
                wr.next    = 1'b1;
                wr.prev    = 1'b1;
                next_waddr = prev_rd;
                next_wdata = next_rd;
                prev_waddr = next_rd;
                prev_wdata = prev_rd;
            end
        end
    end

    // Pick the highest ready level after the edit
    assign found      = |mask_next;
    assign head_raddr = LVL_W'(tzc32(LEVEL_VEC_W'(mask_next)));

    // Hold the bitmap and per-task flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= '0;
            queued_reg   <= '0;
            has_prev_reg <= '0;
            has_next_reg <= '0;
        end
        else
        begin
            mask_reg     <= mask_next;
            queued_reg   <= queued_next;
            has_prev_reg <= has_prev_next;
            has_next_reg <= has_next_next;
        end
    end

    `ASSERT_ALWAYS(a_mask_matches_queued, clk, rst_n, ((mask_reg == '0) == (queued_reg == '0)))
    `ASSERT_NEXT(a_add_marks_task, clk, rst_n, (fire && add_ok), queued_reg[$past(id)])
    `ASSERT_NEXT(a_remove_clears_task, clk, rst_n, (fire && rem_ok), !queued_reg[$past(id)])
    `ASSERT_NEXT(a_add_sets_level, clk, rst_n, (fire && add_ok), (mask_reg != '0))

endmodule

`default_nettype wire

// ===== src/priority_bitmap_ready_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ready queue of task IDs with one FIFO per priority level (level 0 highest).
// Request channel req carries mode (add, remove, query), task_id and task_prio;
// response channel rsp returns found, head_task and status, one per request.
// Both are valid/ready channels; a transfer happens when valid and ready are high.
// A request is taken into an input register; once the output register is free,
// the list edit, the bitmap update and the lowest-set-bit search run and the
// response is loaded into the output register.
// Throughput is one request per cycle while rsp does not stall:
// each link store is written at one address and read at one address per cycle.
// When rsp stalls, the response holds and the input register takes one more
// request; ready then drops until the response is taken.
// Reset empties every level at once through the bitmap and per-task flags;
// no clearing pass runs and requests are taken as soon as reset is released.
// Duplicate adds, removes of absent tasks, out-of-range ids and adds with
// out-of-range levels leave the queue unchanged and return status 1.

module priority_bitmap_ready_queue_core #(
    parameter int NUM_LEVELS = pbrq_pkg::DEF_NUM_LEVELS,
    parameter int MAX_TASKS  = pbrq_pkg::DEF_MAX_TASKS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pbrq_req_if.sink    req,
    pbrq_rsp_if.source  rsp
);

    import pbrq_pkg::*;

    localparam int TID_W = $clog2(MAX_TASKS);
    localparam int LVL_W = $clog2(NUM_LEVELS);

    // Input register
    logic                 s1_valid_reg;
    logic [MODE_W-1:0]    s1_mode_reg;
    logic [TASK_ID_W-1:0] s1_id_reg;
    logic [PRIO_W-1:0]    s1_prio_reg;

    // Output register
    logic out_valid_reg, found_reg, status_reg;

    logic out_free, s1_fire, req_fire;
    logic found, status;

    logic [TID_W-1:0] tail_rd, next_rd, prev_rd, head_rd;
    logic [LVL_W-1:0] level_rd, head_raddr;

    pbrq_wr_en_t      wr;
    logic [LVL_W-1:0] head_waddr, tail_waddr, level_wdata;
    logic [TID_W-1:0] head_wdata, tail_wdata;
    logic [TID_W-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata, level_waddr;

    // Handshake
    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || s1_fire;
    assign req_fire  = req.valid && req.ready;

    // Advance the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_mode_reg <= req.mode;
            s1_id_reg   <= req.task_id;
            s1_prio_reg <= req.task_prio;
        end
    end

    // Per-task and per-level link stores, read as the request is taken
    pbrq_ram #(.WIDTH(TID_W), .DEPTH(MAX_TASKS)) u_next_ram (
        .clk     (clk),
        .wr_en   (wr.next),
        .wr_addr (next_waddr),
        .wr_data (next_wdata),
        .rd_en   (req_fire),
        .rd_addr (TID_W'(req.task_id)),
        .rd_data (next_rd)
    );

    pbrq_ram #(.WIDTH(TID_W), .DEPTH(MAX_TASKS)) u_prev_ram (
        .clk     (clk),
        .wr_en   (wr.prev),
        .wr_addr (prev_waddr),
        .wr_data (prev_wdata),
        .rd_en   (req_fire),
        .rd_addr (TID_W'(req.task_id)),
        .rd_data (prev_rd)
    );

    pbrq_ram #(.WIDTH(LVL_W), .DEPTH(MAX_TASKS)) u_level_ram (
        .clk     (clk),
        .wr_en   (wr.level),
        .wr_addr (level_waddr),
        .wr_data (level_wdata),
        .rd_en   (req_fire),
        .rd_addr (TID_W'(req.task_id)),
        .rd_data (level_rd)
    );

    pbrq_ram #(.WIDTH(TID_W), .DEPTH(NUM_LEVELS)) u_tail_ram (
        .clk     (clk),
        .wr_en   (wr.tail),
        .wr_addr (tail_waddr),
        .wr_data (tail_wdata),
        .rd_en   (req_fire),
        .rd_addr (LVL_W'(req.task_prio)),
        .rd_data (tail_rd)
    );

    // Head store, read at the winning level into the response
    pbrq_ram #(.WIDTH(TID_W), .DEPTH(NUM_LEVELS)) u_head_ram (
        .clk     (clk),
        .wr_en   (wr.head),
        .wr_addr (head_waddr),
        .wr_data (head_wdata),
        .rd_en   (s1_fire),
        .rd_addr (head_raddr),
        .rd_data (head_rd)
    );

    pbrq_link_ctrl #(.NUM_LEVELS(NUM_LEVELS), .MAX_TASKS(MAX_TASKS)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_fire),
        .mode        (s1_mode_reg),
        .task_id     (s1_id_reg),
        .task_prio   (s1_prio_reg),
        .tail_rd     (tail_rd),
        .next_rd     (next_rd),
        .prev_rd     (prev_rd),
        .level_rd    (level_rd),
        .wr          (wr),
        .head_waddr  (head_waddr),
        .head_wdata  (head_wdata),
        .tail_waddr  (tail_waddr),
        .tail_wdata  (tail_wdata),
        .next_waddr  (next_waddr),
        .next_wdata  (next_wdata),
        .prev_waddr  (prev_waddr),
        .prev_wdata  (prev_wdata),
        .level_waddr (level_waddr),
        .level_wdata (level_wdata),
        .head_raddr  (head_raddr),
        .found       (found),
        .status      (status)
    );

    // Load the response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            found_reg  <= found;
            status_reg <= status;
        end
    end

    // Drive the response channel
    assign rsp.valid     = out_valid_reg;
    assign rsp.found     = found_reg;
    assign rsp.status    = status_reg;
    assign rsp.head_task = found_reg ? TASK_ID_W'(head_rd) : '0;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pbrq_pkg::*;

    localparam int NUM_LEVELS = DEF_NUM_LEVELS;
    localparam int NUM_TASKS  = DEF_MAX_TASKS;

    // Modes not named in the package
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // Hold-off length of the long response stall, in cycles
    localparam int LONG_HOLD = 150;

    typedef struct {
        bit                 found;
        bit [TASK_ID_W-1:0] head_task;
        bit                 status;
    } head_report_t;

    logic clk;
    logic rst_n;

    pbrq_req_if req ();
    pbrq_rsp_if rsp ();

    priority_bitmap_ready_queue_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Mirror of the queue contents
    bit [NUM_LEVELS-1:0] level_bits;
    bit [TASK_ID_W-1:0]  first_task [NUM_LEVELS];
    bit [TASK_ID_W-1:0]  last_task  [NUM_LEVELS];
    bit [TASK_ID_W-1:0]  succ_task  [NUM_TASKS];
    bit [TASK_ID_W-1:0]  pred_task  [NUM_TASKS];
    bit [PRIO_W-1:0]     home_level [NUM_TASKS];
    bit                  is_queued  [NUM_TASKS];
    int                  queued_total;

    head_report_t head_reports [$];
    int           error_count;
    bit           idle_on;
    bit           hold_request;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Empty every level
    function automatic void clear_queue_mirror();
        level_bits   = '0;
        queued_total = 0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            is_queued[i] = 1'b0;
        end
    endfunction

    // Apply one request to the mirror and return the report it yields
    function automatic head_report_t run_queue_op(input logic [MODE_W-1:0] mode,
                                                  input logic [TASK_ID_W-1:0] id,
                                                  input logic [PRIO_W-1:0] prio);
        head_report_t       rep;
        int                 lvl;
        bit                 at_head;
        bit                 at_tail;
        bit [TASK_ID_W-1:0] p;
        bit [TASK_ID_W-1:0] n;
        rep = '{found: 1'b0, head_task: '0, status: 1'b0};
        if (mode == MODE_ADD)
        begin
            if (int'(id) >= NUM_TASKS || int'(prio) >= NUM_LEVELS || is_queued[id])
            begin
                rep.status = 1'b1;
            end
            else
            begin
                // append at the tail of the level
                if (!level_bits[prio])
                begin
                    first_task[prio] = id;
                    last_task[prio]  = id;
                    level_bits[prio] = 1'b1;
                end
                else
                begin
                    succ_task[last_task[prio]] = id;
                    pred_task[id]              = last_task[prio];
                    last_task[prio]            = id;
                end
                home_level[id] = prio;
                is_queued[id]  = 1'b1;
                queued_total++;
            end
        end
        else if (mode == MODE_REMOVE)
        begin
            if (int'(id) >= NUM_TASKS || !is_queued[id])
            begin
                rep.status = 1'b1;
            end
            else
            begin
                // unlink from wherever the task sits
                lvl     = home_level[id];
                at_head = (first_task[lvl] == id);
                at_tail = (last_task[lvl] == id);
                if (at_head && at_tail)
                begin
                    level_bits[lvl] = 1'b0;
                end
                else if (at_head)
                begin
                    first_task[lvl] = succ_task[id];
                end
                else if (at_tail)
                begin
                    last_task[lvl] = pred_task[id];
                end
                else
                begin
                    p            = pred_task[id];
                    n            = succ_task[id];
                    succ_task[p] = n;
                    pred_task[n] = p;
                end
                is_queued[id] = 1'b0;
                queued_total--;
            end
        end
        // report the head of the highest ready level
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (level_bits[i] && !rep.found)
            begin
                rep.found     = 1'b1;
                rep.head_task = first_task[i];
            end
        end
        return rep;
    endfunction

    // Random task that is (or is not) queued, -1 when there is none
    function automatic int pick_task(input bit want_queued);
        int pool [$];
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            if (is_queued[i] == want_queued)
            begin
                pool.push_back(i);
            end
        end
        if (pool.size() == 0)
        begin
            return -1;
        end
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    // Mostly short gaps, a few long ones, none while idling is off
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    // Offer one request, wait for it to be taken, record its report
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [TASK_ID_W-1:0] id,
                                input logic [PRIO_W-1:0] prio);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.mode      <= mode;
        req.task_id   <= id;
        req.task_prio <= prio;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        head_reports.push_back(run_queue_op(mode, id, prio));
    endtask

    task automatic test_empty_queue();
        send_request(MODE_QUERY, 6'd0, 5'd0);
        send_request(MODE_SPARE, 6'd63, 5'd31);
        send_request(MODE_REMOVE, 6'd5, 5'd0);
    endtask

    task automatic test_list_edits();
        send_request(MODE_ADD, 6'd0, 5'd31);
        send_request(MODE_ADD, 6'd63, 5'd0);
        send_request(MODE_QUERY, 6'd21, 5'd10);
        // duplicate add keeps the task at its first level
        send_request(MODE_ADD, 6'd63, 5'd5);
        send_request(MODE_ADD, 6'd10, 5'd7);
        send_request(MODE_ADD, 6'd11, 5'd7);
        send_request(MODE_ADD, 6'd12, 5'd7);
        send_request(MODE_ADD, 6'd13, 5'd7);
        // middle, tail, head, then the sole entry of level 0
        send_request(MODE_REMOVE, 6'd11, 5'd0);
        send_request(MODE_REMOVE, 6'd13, 5'd0);
        send_request(MODE_REMOVE, 6'd10, 5'd0);
        send_request(MODE_REMOVE, 6'd63, 5'd31);
        send_request(MODE_QUERY, 6'd0, 5'd0);
        send_request(MODE_REMOVE, 6'd12, 5'd0);
        send_request(MODE_REMOVE, 6'd12, 5'd0);
        // reuse freed links
        send_request(MODE_ADD, 6'd13, 5'd2);
        send_request(MODE_ADD, 6'd10, 5'd2);
        send_request(MODE_REMOVE, 6'd13, 5'd0);
        send_request(MODE_SPARE, 6'd42, 5'd21);
        send_request(MODE_REMOVE, 6'd10, 5'd0);
        send_request(MODE_REMOVE, 6'd0, 5'd0);
        send_request(MODE_QUERY, 6'd63, 5'd31);
    endtask

    // Stall the response side for a long stretch while adds keep coming
    task automatic test_fill_and_stall();
        int id;
        idle_on      = 1'b0;
        hold_request = 1'b1;
        id           = pick_task(1'b0);
        while (id >= 0)
        begin
            send_request(MODE_ADD, id[TASK_ID_W-1:0], PRIO_W'($urandom_range(0, 31)));
            id = pick_task(1'b0);
        end
        // full queue: one more add is a duplicate
        send_request(MODE_ADD, 6'd33, 5'd1);
    endtask

    task automatic test_random_traffic();
        int               r;
        int               id;
        int               add_weight;
        logic [MODE_W-1:0] mode;
        logic [PRIO_W-1:0] prio;
        for (int n = 0; n < 520; n++)
        begin
            if (n % 120 == 0)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            r          = $urandom_range(0, 99);
            add_weight = (queued_total < 40) ? 45 : 25;
            prio       = ($urandom_range(0, 9) < 7) ? PRIO_W'($urandom_range(0, 3))
                                                    : PRIO_W'($urandom_range(0, 31));
            if (r < add_weight)
            begin
                mode = MODE_ADD;
                id   = pick_task(1'b0);
            end
            else if (r < 80)
            begin
                mode = MODE_REMOVE;
                id   = pick_task(1'b1);
            end
            else if (r < 88)
            begin
                mode = ($urandom_range(0, 1) != 0) ? MODE_QUERY : MODE_SPARE;
                id   = $urandom_range(0, 63);
            end
            else if (r < 94)
            begin
                mode = MODE_ADD;
                id   = pick_task(1'b1);
            end
            else
            begin
                mode = MODE_REMOVE;
                id   = pick_task(1'b0);
            end
            // fall back to a query when no suitable task exists
            if (id < 0)
            begin
                mode = MODE_QUERY;
                id   = $urandom_range(0, 63);
            end
            send_request(mode, id[TASK_ID_W-1:0], prio);
        end
    endtask

    task automatic test_drain_all();
        int id;
        idle_on = 1'b1;
        id      = pick_task(1'b1);
        while (id >= 0)
        begin
            send_request(MODE_REMOVE, id[TASK_ID_W-1:0], PRIO_W'($urandom_range(0, 31)));
            id = pick_task(1'b1);
        end
        send_request(MODE_QUERY, 6'd0, 5'd0);
    endtask

    // Response side: random stalls plus the long hold-off on request
    initial
    begin : rsp_driver
        int rsp_hold;
        int rsp_gap;
        rsp_hold  = 0;
        rsp_gap   = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_hold     = LONG_HOLD;
            end
            if (rsp_hold > 0)
            begin
                rsp.ready <= 1'b0;
                rsp_hold--;
            end
            else if (rsp_gap > 0)
            begin
                rsp.ready <= 1'b0;
                rsp_gap--;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                begin
                    rsp_gap = pick_gap();
                end
            end
        end
    end

    // Compare each taken response with the oldest pending report
    always @(posedge clk)
    begin
        head_report_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (head_reports.size() == 0)
            begin
                $error("response with no request pending");
                error_count++;
            end
            else
            begin
                want = head_reports.pop_front();
                if (rsp.found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, rsp.found);
                    error_count++;
                end
                if (rsp.head_task !== want.head_task)
                begin
                    $error("head_task: expected %0d, actual %0d", want.head_task,
                           rsp.head_task);
                    error_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        error_count   = 0;
        idle_on       = 1'b1;
        hold_request  = 1'b0;
        req.valid     = 1'b0;
        req.mode      = MODE_QUERY;
        req.task_id   = '0;
        req.task_prio = '0;
        rst_n         = 1'b0;
        clear_queue_mirror();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_list_edits();
        test_fill_and_stall();
        test_random_traffic();
        test_drain_all();
        req.valid <= 1'b0;

        // wait out the outstanding responses, then idle before the verdict
        while (head_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/pbrq_pkg.sv
src/pbrq_req_if.sv
src/pbrq_rsp_if.sv
src/pbrq_ram.sv
src/pbrq_link_ctrl.sv
src/priority_bitmap_ready_queue_core.sv
tb/sv/tb.sv
